>>> design/trial_division_primality_macros.svh
// assertion macros for the trial division primality block
// used by the checker module, no other dependencies
`ifndef TRIAL_DIVISION_PRIMALITY_MACROS_SVH
`define TRIAL_DIVISION_PRIMALITY_MACROS_SVH

// checked only while out of reset
`define TDP_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TDP_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/tdp_pkg.sv
// shared constants, state types and the wheel step table
// for the trial division primality block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tdp_pkg;

  localparam int VALUE_PORT_BITS = 32;
  localparam int VALUE_BITS_DEF  = 32;
  localparam int FIFO_DEPTH      = 2;
  localparam int SMALL_FIRST     = 2;
  localparam int WHEEL_FIRST     = 11;
  localparam int WHEEL_LEN       = 8;

  typedef enum logic [1:0] {
    F_IDLE,
    F_ROOT,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CHECK,
    B_DIV,
    B_NEXT,
    B_DONE
  } back_state_t;

  function automatic logic [2:0] wheel_step(input logic [2:0] k);
    logic [2:0] s;
    case (k)
      3'd0:    s = 3'd2;
      3'd1:    s = 3'd4;
      3'd2:    s = 3'd2;
      3'd3:    s = 3'd4;
      3'd4:    s = 3'd6;
      3'd5:    s = 3'd2;
      3'd6:    s = 3'd6;
      default: s = 3'd4;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

>>> design/tdp_if.sv
// valid/ready channel interfaces for input values and prime flags
// depends on tdp_pkg for the value width
`timescale 1ns / 1ps
`default_nettype none

interface tdp_in_if import tdp_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic [VALUE_PORT_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface tdp_out_if;
  logic valid;
  logic ready;
  logic is_prime_flag;

  modport source (output valid, output is_prime_flag, input ready);
  modport sink   (input valid, input is_prime_flag, output ready);
endinterface

`default_nettype wire

>>> design/tdp_front.sv
// front end: takes a beat, flags values below two, finds the floor root
// bit by bit and pushes the job into the queue; depends on tdp_pkg
`timescale 1ns / 1ps
`default_nettype none

module tdp_front import tdp_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           in_valid,
  output logic                                           in_ready,
  input  logic [VALUE_PORT_BITS-1:0]                     in_value,
  output logic                                           push,
  input  logic                                           full,
  output logic [1 + (VALUE_BITS + 1) / 2 + VALUE_BITS - 1:0] job
);

  localparam int HALF  = (VALUE_BITS + 1) / 2;
  localparam int W1    = VALUE_BITS + 1;
  localparam int CNT_W = $clog2(HALF + 1);

  front_state_t            state_r, state_nxt;
  logic [VALUE_BITS-1:0]   n_r;
  logic                    small_r;
  logic [W1-1:0]           rem_r, root_r, bit_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [VALUE_BITS+VALUE_PORT_BITS-1:0] ext;
  logic [VALUE_BITS-1:0]   val;
  logic [W1-1:0]           trial;
  logic                    accept;

  assign ext    = {{VALUE_BITS{1'b0}}, in_value};
  assign val    = ext[VALUE_BITS-1:0];
  assign trial  = root_r + bit_r;
  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          state_nxt = (val <= VALUE_BITS'(1)) ? F_PUSH : F_ROOT;
        end
      end
      F_ROOT: begin
        if (cnt_r == '0) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    push     = 1'b0;
    unique case (state_r)
      F_IDLE:  in_ready = 1'b1;
      F_PUSH:  push     = !full;
      default: ;
    endcase
  end

  assign job = {small_r, root_r[HALF-1:0], n_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      n_r     <= val;
      small_r <= (val <= VALUE_BITS'(1));
      rem_r   <= W1'(val);
      root_r  <= '0;
      bit_r   <= W1'(1) << (2 * (HALF - 1));
      cnt_r   <= CNT_W'(HALF - 1);
    end else if (state_r == F_ROOT) begin
      if (rem_r >= trial) begin
        rem_r  <= rem_r - trial;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

>>> design/tdp_fifo.sv
// two-entry job queue between the front and back ends
// depends on tdp_pkg for the depth
`timescale 1ns / 1ps
`default_nettype none

module tdp_fifo import tdp_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [WIDTH-1:0] mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;

  assign full      = (cnt_r == CNT_W'(FIFO_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_r <= (rd_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> design/tdp_back.sv
// back end: walks the small divisors and the mod-30 wheel, one restoring
// remainder bit per cycle, and holds the result register; depends on tdp_pkg
`timescale 1ns / 1ps
`default_nettype none

module tdp_back import tdp_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           job_valid,
  output logic                                           pop,
  input  logic [1 + (VALUE_BITS + 1) / 2 + VALUE_BITS - 1:0] job,
  output logic                                           out_valid,
  input  logic                                           out_ready,
  output logic                                           out_flag
);

  localparam int HALF  = (VALUE_BITS + 1) / 2;
  localparam int D_W   = HALF + 6;
  localparam int CNT_W = $clog2(VALUE_BITS);

  back_state_t           state_r, state_nxt;
  logic [VALUE_BITS-1:0] n_r, nsh_r;
  logic [HALF-1:0]       bound_r;
  logic                  small_r;
  logic [D_W-1:0]        d_r;
  logic [D_W-1:0]        rem_r;
  logic                  wheel_r;
  logic [2:0]            k_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  prime_r;
  logic                  out_valid_r, out_flag_r;

  logic [D_W:0]          trial;
  logic [D_W-1:0]        rem_nxt;
  logic                  in_bound;
  logic                  do_div;
  logic                  slot_free;
  logic                  job_small;
  logic [HALF-1:0]       job_bound;
  logic [VALUE_BITS-1:0] job_n;

  assign {job_small, job_bound, job_n} = job;

  assign trial     = {rem_r, nsh_r[VALUE_BITS-1]};
  assign rem_nxt   = (trial >= {1'b0, d_r}) ? D_W'(trial - {1'b0, d_r}) : trial[D_W-1:0];
  assign in_bound  = (d_r <= D_W'(bound_r));
  assign slot_free = !out_valid_r || out_ready;

  // start a trial when the next candidate is at or under the root bound; on the wheel, also while a turn is under way
  always_comb begin
    if (!wheel_r) begin
      do_div = in_bound;
    end else begin
      do_div = (k_r != 3'd0) || in_bound;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (job_valid) begin
          state_nxt = job_small ? B_DONE : B_CHECK;
        end
      end
      B_CHECK: state_nxt = do_div ? B_DIV : B_DONE;
      B_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = B_NEXT;
        end
      end
      B_NEXT:  state_nxt = (rem_r == '0) ? B_DONE : B_CHECK;
      B_DONE: begin
        if (slot_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    unique case (state_r)
      B_IDLE:  pop = job_valid;
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_flag  = out_flag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_DONE && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        n_r     <= job_n;
        bound_r <= job_bound;
        small_r <= job_small;
        d_r     <= D_W'(SMALL_FIRST);
        wheel_r <= 1'b0;
        k_r     <= '0;
        prime_r <= 1'b0;
      end
      B_CHECK: begin
        nsh_r <= n_r;
        rem_r <= '0;
        cnt_r <= CNT_W'(VALUE_BITS - 1);
        prime_r <= !small_r;
        if (!wheel_r && d_r == D_W'(WHEEL_FIRST)) begin
          wheel_r <= 1'b1;
        end
      end
      B_DIV: begin
        rem_r <= rem_nxt;
        nsh_r <= nsh_r << 1;
        cnt_r <= cnt_r - CNT_W'(1);
      end
      B_NEXT: begin
        if (rem_r == '0) begin
          prime_r <= 1'b0;
        end
        if (!wheel_r) begin
          d_r <= d_r + D_W'(1);
        end else begin
          d_r <= d_r + D_W'(wheel_step(k_r));
          k_r <= k_r + 3'd1;
        end
      end
      B_DONE: begin
        if (slot_free) begin
          out_flag_r <= prime_r && !small_r;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> design/trial_division_primality.sv
// trial division primality test, top level with valid/ready channels
// depends on tdp_pkg, tdp_if, tdp_front, tdp_fifo and tdp_back
`timescale 1ns / 1ps
`default_nettype none

// Each input beat carries one value (low VALUE_BITS bits used) and yields one
// beat with is_prime_flag set when the value is prime. The front end takes a
// value, works out the floor root bit-serially, then parks the job in a
// two-entry queue. The back end tries divisors 2..10 and then the mod-30 wheel
// from 11 up to the root, finishing any turn of the wheel it has begun; each
// candidate passes through the one-bit-per-cycle remainder unit, which sets
// the rate. A 32-bit prime near the top of the range needs about 17500
// candidates; values below two skip the root and the trials, and values with
// a small factor stop after the root and a few candidates. Results leave in
// input order through an output register, so the next job runs while a
// result waits.
module trial_division_primality import tdp_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  tdp_in_if.sink   in_ch,
  tdp_out_if.source out_ch
);

  localparam int HALF = (VALUE_BITS + 1) / 2;
  localparam int JOB_W = 1 + HALF + VALUE_BITS;

  logic             push, full, pop, job_valid;
  logic [JOB_W-1:0] job_in, job_out;
  logic             out_valid, out_flag;

  tdp_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_value (in_ch.value),
    .push     (push),
    .full     (full),
    .job      (job_in)
  );

  tdp_fifo #(.WIDTH(JOB_W)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (job_in),
    .full      (full),
    .pop       (pop),
    .not_empty (job_valid),
    .pop_data  (job_out)
  );

  tdp_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .pop       (pop),
    .job       (job_out),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_flag  (out_flag)
  );

  assign out_ch.valid         = out_valid;
  assign out_ch.is_prime_flag = out_flag;

endmodule

`default_nettype wire

>>> design/tdp_checker.sv
// port-level checks for the trial division primality block, bound to the top
// depends on trial_division_primality_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "trial_division_primality_macros.svh"

module tdp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // front, two queue slots, back and output register
  localparam logic [3:0] MAX_OPEN = 4'd5;

  logic [3:0] open_r;
  logic       in_beat, out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
    end else if (in_beat && !out_beat) begin
      open_r <= open_r + 4'd1;
    end else if (out_beat && !in_beat) begin
      open_r <= open_r - 4'd1;
    end
  end

  `TDP_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `TDP_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "result valid right after reset")
  `TDP_ASSERT(a_no_spurious, clk, rst_n, out_valid |-> open_r != 4'd0, "result without a pending value")
  `TDP_ASSERT(a_bounded, clk, rst_n, open_r <= MAX_OPEN, "more values in flight than storage")

endmodule

bind trial_division_primality tdp_checker u_tdp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);

`default_nettype wire
